### hdl/pifmt_pkg.sv
package pifmt_pkg;

   localparam int MAX_FIELD  = 64;
   localparam int PREC_MAX   = MAX_FIELD - 2;
   localparam int CNT_W      = $clog2(MAX_FIELD + 1);
   localparam int PREC_W     = $clog2(PREC_MAX + 1);
   localparam int VALUE_W    = 32;
   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = VALUE_W / 4;
   localparam int BCD_W      = 4 * DEC_DIGITS;
   localparam int NDIG_W     = $clog2(DEC_DIGITS + 1);
   localparam int STEP_W     = $clog2(VALUE_W);

   localparam logic [1:0] OP_SIGNED_DEC   = 2'd0;
   localparam logic [1:0] OP_UNSIGNED_DEC = 2'd1;
   localparam logic [1:0] OP_HEX_LOWER    = 2'd2;
   localparam logic [1:0] OP_HEX_UPPER    = 2'd3;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_NORM,
      ST_SIZE,
      ST_BOUND,
      ST_EMIT
   } state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + {4'd0, d};
      end else begin
         digit_char = base + {4'd0, d} - 8'd10;
      end
   endfunction

endpackage

### hdl/pifmt_bcd.sv
module pifmt_bcd (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pifmt_pkg::VALUE_W-1:0] binary,
   output logic                          done,
   output logic [pifmt_pkg::BCD_W-1:0]   bcd
);
   import pifmt_pkg::*;

   logic [VALUE_W-1:0] bin_ff;
   logic [BCD_W-1:0]   bcd_ff;
   logic [BCD_W-1:0]   adj;
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff;
   logic               done_ff;

   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff <= binary;
         bcd_ff <= '0;
      end else if (busy_ff) begin
         bin_ff <= {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_ff <= {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

### hdl/printf_integer_field_formatter.sv
// Integer field formatter for printf-style d, u, x and X conversions.
// An item enters on the req_ channel with its conversion kind, value, flags,
// field width and precision. The formatted text leaves on the rsp_ channel,
// one ASCII character per item, with rsp_last set on the final character.
// A field that yields no characters gives a single item with character 0,
// rsp_empty_res and rsp_last set.
// One item is formatted at a time; req_stall is high from acceptance until
// the last character has been loaded into the output register.
// Decimal items pass through a bit-serial binary to BCD converter, then
// leading zero digits are shifted out one at a time (up to 9); hex items
// skip the converter and shift out up to 7 leading zero digits. The ST_SIZE
// and ST_BOUND states then size the field, and one character is emitted per
// cycle unless rsp_stall holds a pending item in the output register.
// When the receiver raises rsp_stall, the output register holds its item and
// emission pauses. Reset is synchronous and returns the block to idle with
// the output channel empty.
module printf_integer_field_formatter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [31:0]                   req_value,
   input  logic                          req_flag_minus,
   input  logic                          req_flag_plus,
   input  logic                          req_flag_space,
   input  logic                          req_flag_zero,
   input  logic                          req_flag_hash,
   input  logic [6:0]                    req_field_width,
   input  logic signed [6:0]             req_min_digits,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_character,
   output logic                          rsp_empty_res,
   output logic                          rsp_last
);
   import pifmt_pkg::*;

   state_type state_ff, state_in;

   logic                 accept;
   logic                 slot_free;
   logic                 emit;
   logic                 emit_last;
   logic                 bcd_start;
   logic                 bcd_done;
   logic [BCD_W-1:0]     bcd_value;
   logic [VALUE_W-1:0]   mag;
   logic                 is_dec;

   logic [BCD_W-1:0]     dig_ff;
   logic [NDIG_W-1:0]    nd_ff;
   logic [NDIG_W-1:0]    ndig_ff;
   logic                 minus_ff;
   logic                 upper_ff;
   logic                 zero_ff;
   logic                 mag_zero_ff;
   logic                 prec_given_ff;
   logic [PREC_W-1:0]    prec_ff;
   logic [1:0]           prelen_ff;
   logic [7:0]           pre0_ff;
   logic [7:0]           pre1_ff;
   logic [CNT_W-1:0]     width_ff;
   logic [CNT_W-1:0]     zpad_ff;
   logic [CNT_W-1:0]     b1_ff, b2_ff, b3_ff, b4_ff, total_ff;
   logic [CNT_W-1:0]     k_ff;

   logic [NDIG_W-1:0]    ndig_c;
   logic [CNT_W-1:0]     zpad_c;
   logic [CNT_W-1:0]     lead_c;
   logic [CNT_W-1:0]     body_c;
   logic [CNT_W-1:0]     spad_c;
   logic [CNT_W-1:0]     b1_c;
   logic [7:0]           char_c;

   logic                 rsp_valid_ff;
   logic [7:0]           rsp_character_ff;
   logic                 rsp_empty_res_ff;
   logic                 rsp_last_ff;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_dec    = (req_operation == OP_SIGNED_DEC) || (req_operation == OP_UNSIGNED_DEC);
   assign mag       = ((req_operation == OP_SIGNED_DEC) && req_value[VALUE_W-1]) ?
                      (~req_value + 1'b1) : req_value;
   assign bcd_start = accept && is_dec;

   pifmt_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .binary (mag),
      .done   (bcd_done),
      .bcd    (bcd_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = is_dec ? ST_CONVERT : ST_NORM;
            end
         end
         ST_CONVERT: begin
            if (bcd_done) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!(dig_ff[BCD_W-1 -: 4] == 4'd0 && nd_ff > NDIG_W'(1))) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            emit = slot_free;
            if (slot_free && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ndig_c = (prec_given_ff && prec_ff == '0 && mag_zero_ff) ? '0 : nd_ff;
   assign lead_c = CNT_W'(ndig_c) + CNT_W'(prelen_ff);

   always_comb begin
      if (prec_given_ff && CNT_W'(prec_ff) > CNT_W'(ndig_c)) begin
         zpad_c = CNT_W'(prec_ff) - CNT_W'(ndig_c);
      end else if (zero_ff && !minus_ff && width_ff > lead_c) begin
         zpad_c = width_ff - lead_c;
      end else begin
         zpad_c = '0;
      end
   end

   assign body_c = CNT_W'(prelen_ff) + zpad_ff + CNT_W'(ndig_ff);
   assign spad_c = (width_ff > body_c) ? (width_ff - body_c) : '0;
   assign b1_c   = minus_ff ? '0 : spad_c;

   assign emit_last = (total_ff == '0) || (k_ff + 1'b1 == total_ff);

   always_comb begin
      if (total_ff == '0) begin
         char_c = CHAR_NUL;
      end else if (k_ff < b1_ff) begin
         char_c = CHAR_SPACE;
      end else if (k_ff < b2_ff) begin
         char_c = (k_ff == b1_ff) ? pre0_ff : pre1_ff;
      end else if (k_ff < b3_ff) begin
         char_c = CHAR_ZERO;
      end else if (k_ff < b4_ff) begin
         char_c = digit_char(dig_ff[BCD_W-1 -: 4], upper_ff);
      end else begin
         char_c = CHAR_SPACE;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_zero_ff   <= (req_value == '0);
         minus_ff      <= req_flag_minus;
         upper_ff      <= (req_operation == OP_HEX_UPPER);
         prec_given_ff <= !req_min_digits[6];
         zero_ff       <= req_flag_zero && req_min_digits[6];
         if (req_min_digits[5:0] > 6'(PREC_MAX)) begin
            prec_ff <= PREC_W'(PREC_MAX);
         end else begin
            prec_ff <= PREC_W'(req_min_digits[5:0]);
         end
         if (req_field_width > 7'(MAX_FIELD)) begin
            width_ff <= CNT_W'(MAX_FIELD);
         end else begin
            width_ff <= CNT_W'(req_field_width);
         end
         prelen_ff <= 2'd0;
         pre0_ff   <= CHAR_ZERO;
         pre1_ff   <= (req_operation == OP_HEX_UPPER) ? CHAR_UPPER_X : CHAR_LOWER_X;
         if (req_operation == OP_SIGNED_DEC) begin
            if (req_value[VALUE_W-1]) begin
               prelen_ff <= 2'd1;
               pre0_ff   <= CHAR_MINUS;
            end else if (req_flag_plus) begin
               prelen_ff <= 2'd1;
               pre0_ff   <= CHAR_PLUS;
            end else if (req_flag_space) begin
               prelen_ff <= 2'd1;
               pre0_ff   <= CHAR_SPACE;
            end
         end else if (!is_dec && req_flag_hash && req_value != '0) begin
            prelen_ff <= 2'd2;
         end
         dig_ff <= {mag, {(BCD_W - VALUE_W){1'b0}}};
         nd_ff  <= NDIG_W'(HEX_DIGITS);
      end else if (state_ff == ST_CONVERT && bcd_done) begin
         dig_ff <= bcd_value;
         nd_ff  <= NDIG_W'(DEC_DIGITS);
      end else if (state_ff == ST_NORM) begin
         if (dig_ff[BCD_W-1 -: 4] == 4'd0 && nd_ff > NDIG_W'(1)) begin
            dig_ff <= {dig_ff[BCD_W-5:0], 4'd0};
            nd_ff  <= nd_ff - 1'b1;
         end
      end else if (state_ff == ST_SIZE) begin
         ndig_ff <= ndig_c;
         zpad_ff <= zpad_c;
      end else if (state_ff == ST_BOUND) begin
         b1_ff    <= b1_c;
         b2_ff    <= b1_c + CNT_W'(prelen_ff);
         b3_ff    <= b1_c + CNT_W'(prelen_ff) + zpad_ff;
         b4_ff    <= body_c + b1_c;
         total_ff <= body_c + spad_c;
         k_ff     <= '0;
      end else if (emit) begin
         k_ff <= k_ff + 1'b1;
         if (k_ff >= b3_ff && k_ff < b4_ff) begin
            dig_ff <= {dig_ff[BCD_W-5:0], 4'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_character_ff <= char_c;
         rsp_empty_res_ff <= (total_ff == '0);
         rsp_last_ff      <= emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_empty_res = rsp_empty_res_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### sim/tb_printf_integer_field_formatter.sv
module tb_printf_integer_field_formatter;
   import pifmt_pkg::*;

   localparam int RANDOM_FIELDS = 320;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int REPORT_MAX    = 10;

   localparam logic [4:0] F_NONE  = 5'b00000;
   localparam logic [4:0] F_MINUS = 5'b10000;
   localparam logic [4:0] F_PLUS  = 5'b01000;
   localparam logic [4:0] F_SPACE = 5'b00100;
   localparam logic [4:0] F_ZERO  = 5'b00010;
   localparam logic [4:0] F_HASH  = 5'b00001;

   localparam bit CALC    = 1'b0;
   localparam bit LITERAL = 1'b1;

   localparam logic signed [6:0] NO_PREC = -7'sd1;

   typedef struct {
      logic [1:0]        op;
      logic [31:0]       value;
      logic              minus;
      logic              plus;
      logic              space;
      logic              zero;
      logic              hash;
      logic [6:0]        width;
      logic signed [6:0] prec;
   } field_req_type;

   typedef struct {
      logic [7:0] ch;
      logic       empty;
      logic       last;
   } field_char_type;

   typedef struct {
      logic [1:0]        op;
      logic [31:0]       value;
      logic [4:0]        flags;
      logic [6:0]        width;
      logic signed [6:0] prec;
      bit                typed;
      string             text;
   } field_case_type;

   typedef logic [7:0] char_q_type[$];

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_operation = OP_SIGNED_DEC;
   logic [31:0]       req_value = '0;
   logic              req_flag_minus = 1'b0;
   logic              req_flag_plus = 1'b0;
   logic              req_flag_space = 1'b0;
   logic              req_flag_zero = 1'b0;
   logic              req_flag_hash = 1'b0;
   logic [6:0]        req_field_width = '0;
   logic signed [6:0] req_min_digits = NO_PREC;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_character;
   logic              rsp_empty_res;
   logic              rsp_last;

   field_char_type pending_chars[$];
   bit             steady = 1'b0;
   int             fields_sent = 0;
   int             chars_checked = 0;
   int             error_count = 0;
   int             idle_cycles = 0;

   field_case_type directed_fields[25] = '{
      '{OP_SIGNED_DEC,   32'h8000_0000, F_NONE,           7'd0,   NO_PREC, LITERAL, "-2147483648"},
      '{OP_SIGNED_DEC,   32'h7FFF_FFFF, F_PLUS,           7'd0,   NO_PREC, LITERAL, "+2147483647"},
      '{OP_UNSIGNED_DEC, 32'hFFFF_FFFF, F_NONE,           7'd0,   NO_PREC, LITERAL, "4294967295"},
      '{OP_HEX_LOWER,    32'hFFFF_FFFF, F_HASH,           7'd0,   NO_PREC, LITERAL, "0xffffffff"},
      '{OP_HEX_UPPER,    32'hDEAD_BEEF, F_HASH,           7'd0,   NO_PREC, LITERAL, "0XDEADBEEF"},
      '{OP_HEX_UPPER,    32'h0,         F_HASH,           7'd0,   NO_PREC, LITERAL, "0"},
      '{OP_UNSIGNED_DEC, 32'h0,         F_NONE,           7'd0,   7'sd0,   LITERAL, ""},
      '{OP_SIGNED_DEC,   32'h0,         F_PLUS,           7'd0,   7'sd0,   LITERAL, "+"},
      '{OP_SIGNED_DEC,   32'h0,         F_SPACE,          7'd0,   7'sd0,   LITERAL, " "},
      '{OP_SIGNED_DEC,   32'd42,        F_MINUS,          7'd64,  NO_PREC, CALC,    ""},
      '{OP_SIGNED_DEC,   -32'sd42,      F_ZERO,           7'd8,   NO_PREC, LITERAL, "-0000042"},
      '{OP_SIGNED_DEC,   32'd42,        F_ZERO,           7'd8,   7'sd3,   LITERAL, "     042"},
      '{OP_UNSIGNED_DEC, 32'd7,         F_NONE,           7'd127, NO_PREC, CALC,    ""},
      '{OP_SIGNED_DEC,   32'd5,         F_NONE,           7'd0,   7'sd63,  CALC,    ""},
      '{OP_HEX_LOWER,    32'h0,         F_HASH,           7'd4,   7'sd0,   LITERAL, "    "},
      '{OP_UNSIGNED_DEC, 32'd5,         F_ZERO,           7'd3,   -7'sd64, LITERAL, "005"},
      '{OP_UNSIGNED_DEC, 32'd123,       F_PLUS | F_SPACE, 7'd0,   NO_PREC, LITERAL, "123"},
      '{OP_SIGNED_DEC,   32'd123,       F_HASH,           7'd0,   NO_PREC, LITERAL, "123"},
      '{OP_HEX_UPPER,    32'hAB,        F_HASH | F_ZERO,  7'd8,   NO_PREC, LITERAL, "0X0000AB"},
      '{OP_HEX_LOWER,    32'h1,         F_HASH | F_MINUS, 7'd6,   NO_PREC, LITERAL, "0x1   "},
      '{OP_SIGNED_DEC,   32'hFFFF_FFFF, F_NONE,           7'd5,   7'sd3,   LITERAL, " -001"},
      '{OP_UNSIGNED_DEC, 32'h0,         F_ZERO | F_MINUS, 7'd64,  7'sd62,  CALC,    ""},
      '{OP_SIGNED_DEC,   32'd1,         F_PLUS | F_SPACE, 7'd0,   NO_PREC, LITERAL, "+1"},
      '{OP_HEX_LOWER,    32'h0123_ABCD, F_NONE,           7'd0,   7'sd10,  LITERAL, "000123abcd"},
      '{OP_SIGNED_DEC,   32'h0,         F_ZERO | F_PLUS,  7'd64,  NO_PREC, CALC,    ""}
   };

   printf_integer_field_formatter i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_pause();
      return steady ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic void queue_chars(input char_q_type text);
      field_char_type c;
      if (text.size() == 0) begin
         c = '{CHAR_NUL, 1'b1, 1'b1};
         pending_chars.push_back(c);
      end else begin
         foreach (text[k]) begin
            c = '{text[k], 1'b0, k == text.size() - 1};
            pending_chars.push_back(c);
         end
      end
   endfunction

   function automatic void format_field(input field_req_type r);
      int          width_eff;
      int          prec;
      int          prelen;
      int          ndig;
      int          zpad;
      int          spad;
      logic [31:0] mag;
      logic [31:0] rest;
      logic [31:0] radix;
      logic [3:0]  d;
      logic [7:0]  pfx[2];
      logic [7:0]  rev[16];
      char_q_type  text;
      width_eff = (r.width > MAX_FIELD) ? MAX_FIELD : int'(r.width);
      prec = r.prec;
      if (prec > PREC_MAX) prec = PREC_MAX;
      if (prec < 0) prec = -1;
      mag = r.value;
      prelen = 0;
      if (r.op == OP_SIGNED_DEC) begin
         if (r.value[31]) begin
            mag = -r.value;
            pfx[0] = CHAR_MINUS;
            prelen = 1;
         end else if (r.plus) begin
            pfx[0] = CHAR_PLUS;
            prelen = 1;
         end else if (r.space) begin
            pfx[0] = CHAR_SPACE;
            prelen = 1;
         end
      end else if (r.op != OP_UNSIGNED_DEC && r.hash && r.value != 0) begin
         pfx[0] = CHAR_ZERO;
         pfx[1] = (r.op == OP_HEX_UPPER) ? CHAR_UPPER_X : CHAR_LOWER_X;
         prelen = 2;
      end
      radix = (r.op == OP_SIGNED_DEC || r.op == OP_UNSIGNED_DEC) ? 32'd10 : 32'd16;
      rest = mag;
      ndig = 0;
      do begin
         d = 4'(rest % radix);
         if (d < 4'd10) begin
            rev[ndig] = CHAR_ZERO + 8'(d);
         end else begin
            rev[ndig] = ((r.op == OP_HEX_UPPER) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(d) - 8'd10;
         end
         ndig++;
         rest = rest / radix;
      end while (rest != 0);
      if (prec == 0 && mag == 0) ndig = 0;
      zpad = 0;
      if (prec > ndig) begin
         zpad = prec - ndig;
      end else if (r.zero && prec < 0 && !r.minus && width_eff > ndig + prelen) begin
         zpad = width_eff - (ndig + prelen);
      end
      spad = (width_eff > prelen + zpad + ndig) ? width_eff - (prelen + zpad + ndig) : 0;
      if (!r.minus) repeat (spad) text.push_back(CHAR_SPACE);
      for (int i = 0; i < prelen; i++) text.push_back(pfx[i]);
      repeat (zpad) text.push_back(CHAR_ZERO);
      for (int i = ndig - 1; i >= 0; i--) text.push_back(rev[i]);
      if (r.minus) repeat (spad) text.push_back(CHAR_SPACE);
      queue_chars(text);
   endfunction

   function automatic field_req_type random_field();
      field_req_type r;
      logic [4:0]    flags;
      logic [31:0]   extremes[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1};
      r.op = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0: r.value = '0;
         1: r.value = $urandom_range(0, 20);
         2: r.value = extremes[$urandom_range(0, 3)];
         3: r.value = -$urandom_range(1, 1000);
         default: r.value = $urandom >> $urandom_range(0, 31);
      endcase
      flags = 5'($urandom);
      r.minus = flags[4];
      r.plus  = flags[3];
      r.space = flags[2];
      r.zero  = flags[1];
      r.hash  = flags[0];
      r.width = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 20));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r.prec = NO_PREC;
         4: r.prec = 7'($urandom);
         default: r.prec = 7'($urandom_range(0, 12));
      endcase
      return r;
   endfunction

   task automatic send_field(input field_req_type r, input bit typed, input string text);
      int         gap;
      char_q_type chars;
      gap = draw_pause();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= r.op;
      req_value       <= r.value;
      req_flag_minus  <= r.minus;
      req_flag_plus   <= r.plus;
      req_flag_space  <= r.space;
      req_flag_zero   <= r.zero;
      req_flag_hash   <= r.hash;
      req_field_width <= r.width;
      req_min_digits  <= r.prec;
      do @(posedge clock); while (req_stall);
      if (typed) begin
         for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
         queue_chars(chars);
      end else begin
         format_field(r);
      end
      fields_sent++;
   endtask

   // The receiver holds off for a drawn number of cycles before taking each item.
   initial begin
      int n;
      wait (!reset);
      forever begin
         n = draw_pause();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      field_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
               $display("Unexpected item: ch=%h empty=%b last=%b",
                        rsp_character, rsp_empty_res, rsp_last);
            end
         end else begin
            want = pending_chars.pop_front();
            if (want.ch !== rsp_character || want.empty !== rsp_empty_res ||
                want.last !== rsp_last) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("Mismatch at item %0d: expected ch=%h empty=%b last=%b,",
                           chars_checked, want.ch, want.empty, want.last);
                  $display("   got ch=%h empty=%b last=%b",
                           rsp_character, rsp_empty_res, rsp_last);
               end
            end
         end
         chars_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      field_req_type  r;
      field_case_type fc;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_fields[i]) begin
         fc = directed_fields[i];
         r.op    = fc.op;
         r.value = fc.value;
         r.minus = (fc.flags & F_MINUS) != 0;
         r.plus  = (fc.flags & F_PLUS) != 0;
         r.space = (fc.flags & F_SPACE) != 0;
         r.zero  = (fc.flags & F_ZERO) != 0;
         r.hash  = (fc.flags & F_HASH) != 0;
         r.width = fc.width;
         r.prec  = fc.prec;
         send_field(r, fc.typed, fc.text);
      end
      for (int i = 0; i < RANDOM_FIELDS; i++) begin
         // Every 40 fields, a draw picks a run of back-to-back traffic or of random gaps.
         if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         send_field(random_field(), CALC, "");
      end
      req_valid <= 1'b0;
      wait (pending_chars.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Formatted %0d fields (%0d directed, %0d random) into %0d output items.",
               fields_sent, $size(directed_fields), RANDOM_FIELDS, chars_checked);
      $display("Mismatches: %0d, items still pending: %0d.", error_count,
               pending_chars.size());
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
hdl/pifmt_pkg.sv
hdl/pifmt_bcd.sv
hdl/printf_integer_field_formatter.sv
sim/tb_printf_integer_field_formatter.sv
